// File: hdl/lcds_pkg.sv
// Shared types and constants for the LBA to CHS DMA splitter.
// No dependencies; every other file of the block refers to it by scoped names.
package lcds_pkg;

  localparam int BLK_W       = 26;
  localparam int ADDR_W      = 20;
  localparam int CNT_W       = 6;
  localparam int HEADS_W     = 8;
  localparam int SPT_W       = 6;
  localparam int CYL_W       = 12;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 20;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_HEADS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE    = 2'd2;

  localparam logic [HEADS_W-1:0] RST_RAW_HEADS = 8'd16;
  localparam logic [SPT_W-1:0]   RST_SPT       = 6'd63;
  localparam logic [ADDR_W-1:0]  RST_BOUNCE    = 20'd0;

  // Type-3 translation: raw count at or above this with low six bits at 16
  localparam logic [HEADS_W-1:0] TYPE3_MIN   = 8'h40;
  localparam logic [5:0]         TYPE3_HEADS = 6'd16;

  typedef enum logic {
    DIV_SEC,
    DIV_CYL
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_e div_sel;
    logic     cap_sec;
    logic     cap_cyl;
    logic     emit;
  } lcds_cmd_t;

  typedef struct packed {
    logic in_empty;
    logic div_done;
    logic last_chunk;
    logic out_free;
  } lcds_sts_t;

endpackage

// File: hdl/lcds_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Uses lcds_pkg for the dividend and divisor widths.
module lcds_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lcds_pkg::BLK_W-1:0]    dividend_i,
  input  logic [lcds_pkg::HEADS_W-1:0]  divisor_i,
  output logic [lcds_pkg::BLK_W-1:0]    quotient_o,
  output logic [lcds_pkg::HEADS_W-1:0]  remainder_o,
  output logic                          done_o
);

  localparam int STEP_W = $clog2(lcds_pkg::BLK_W);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [STEP_W-1:0]             step_q, step_d;
  logic [lcds_pkg::HEADS_W-1:0]  rem_q, rem_d;
  logic [lcds_pkg::HEADS_W-1:0]  dvs_q, dvs_d;
  logic [lcds_pkg::BLK_W-1:0]    quo_q, quo_d;
  logic [lcds_pkg::HEADS_W:0]    trial;
  logic                          fits;

  assign trial = {rem_q, quo_q[lcds_pkg::BLK_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(lcds_pkg::BLK_W - 1);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      // trial stays below twice the divisor, so the difference fits
      rem_d  = fits ? lcds_pkg::HEADS_W'(trial - {1'b0, dvs_q}) : trial[lcds_pkg::HEADS_W-1:0];
      quo_d  = {quo_q[lcds_pkg::BLK_W-2:0], fits};
      step_d = step_q - 1'b1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign done_o      = done_q;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");
`endif

endmodule

// File: hdl/lcds_dp.sv
// Datapath: configuration, request registers, CHS split, chunk sizing, output register.
// Uses lcds_pkg and lcds_div.
module lcds_dp #(
  parameter int BLOCK_BYTES      = 512,
  parameter int DMA_WINDOW_BYTES = 65536
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lcds_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lcds_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [lcds_pkg::IN_TDATA_W-1:0]     s_tdata_i,
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  output logic [lcds_pkg::OUT_TDATA_W-1:0]    m_tdata_o,
  output logic                                m_tlast_o,
  output logic                                m_tuser_o,
  input  lcds_pkg::lcds_cmd_t                 cmd_i,
  output lcds_pkg::lcds_sts_t                 sts_o
);

  localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int WIN_BITS  = $clog2(DMA_WINDOW_BYTES);
  localparam int ROOM_W    = WIN_BITS + 1;

  // configuration
  logic [lcds_pkg::HEADS_W-1:0] raw_heads_q;
  logic [lcds_pkg::SPT_W-1:0]   spt_q;
  logic [lcds_pkg::ADDR_W-1:0]  bounce_q;

  // request and chunk state
  logic [lcds_pkg::BLK_W-1:0]   blk_q;
  logic [lcds_pkg::ADDR_W-1:0]  addr_q;
  logic [lcds_pkg::CNT_W-1:0]   left_q;
  logic [lcds_pkg::BLK_W-1:0]   track_q;
  logic [lcds_pkg::SPT_W-1:0]   sec_q;
  logic [lcds_pkg::HEADS_W-1:0] head_q;
  logic [lcds_pkg::CYL_W-1:0]   cyl_q;

  logic                           out_valid_q;
  logic [lcds_pkg::OUT_TDATA_W-1:0] out_data_q;
  logic                           out_last_q;
  logic                           out_user_q;

  logic [lcds_pkg::HEADS_W-1:0] heads_t3;
  logic [lcds_pkg::HEADS_W-1:0] heads_eff;
  logic [lcds_pkg::SPT_W-1:0]   spt_eff;
  logic                         type3;

  logic [lcds_pkg::BLK_W-1:0]   div_dividend;
  logic [lcds_pkg::HEADS_W-1:0] div_divisor;
  logic [lcds_pkg::BLK_W-1:0]   div_quo;
  logic [lcds_pkg::HEADS_W-1:0] div_rem;
  logic                         div_done;

  logic [WIN_BITS-1:0]          win_low;
  logic [ROOM_W-1:0]            room;
  logic [ROOM_W-1:0]            room_blk;
  logic [lcds_pkg::SPT_W-1:0]   sec_room;
  logic [ROOM_W-1:0]            cnt_a, cnt_b;
  logic                         bounce;
  logic [lcds_pkg::CNT_W-1:0]   count;
  logic [lcds_pkg::ADDR_W-1:0]  xfer;
  logic [7:0]                   head_byte;
  logic [7:0]                   sector_byte;

  // effective geometry
  assign type3     = (raw_heads_q >= lcds_pkg::TYPE3_MIN) && (raw_heads_q[5:0] == lcds_pkg::TYPE3_HEADS);
  assign heads_t3  = type3 ? {2'b00, raw_heads_q[5:0]} : raw_heads_q;
  assign heads_eff = (heads_t3 == '0) ? lcds_pkg::HEADS_W'(1) : heads_t3;
  assign spt_eff   = (spt_q == '0) ? lcds_pkg::SPT_W'(1) : spt_q;

  // block / spt gives the track and sector, track / heads gives cylinder and head
  assign div_dividend = (cmd_i.div_sel == lcds_pkg::DIV_SEC) ? blk_q : track_q;
  assign div_divisor  = (cmd_i.div_sel == lcds_pkg::DIV_SEC) ? {2'b00, spt_eff} : heads_eff;

  lcds_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .quotient_o  (div_quo),
    .remainder_o (div_rem),
    .done_o      (div_done)
  );

  // chunk size: limited by request, DMA window and end of track
  assign win_low  = addr_q[WIN_BITS-1:0];
  assign room     = ROOM_W'(DMA_WINDOW_BYTES) - {1'b0, win_low};
  assign bounce   = room < ROOM_W'(BLOCK_BYTES);
  assign room_blk = room >> BLK_SHIFT;
  assign sec_room = spt_eff - sec_q;
  assign cnt_a    = (room_blk < ROOM_W'(left_q)) ? room_blk : ROOM_W'(left_q);
  assign cnt_b    = (ROOM_W'(sec_room) < cnt_a) ? ROOM_W'(sec_room) : cnt_a;
  assign count    = bounce ? lcds_pkg::CNT_W'(1) : cnt_b[lcds_pkg::CNT_W-1:0];
  assign xfer     = bounce ? bounce_q : addr_q;

  assign head_byte   = head_q + {cyl_q[11:10], 6'b0};
  assign sector_byte = {2'b00, sec_q} + 8'd1 + {cyl_q[9:8], 6'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_heads_q <= lcds_pkg::RST_RAW_HEADS;
      spt_q       <= lcds_pkg::RST_SPT;
      bounce_q    <= lcds_pkg::RST_BOUNCE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lcds_pkg::CFG_RAW_HEADS: raw_heads_q <= cfg_data_i[lcds_pkg::HEADS_W-1:0];
        lcds_pkg::CFG_SPT:       spt_q       <= cfg_data_i[lcds_pkg::SPT_W-1:0];
        lcds_pkg::CFG_BOUNCE:    bounce_q    <= cfg_data_i[lcds_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      blk_q  <= s_tdata_i[25:0];
      addr_q <= s_tdata_i[45:26];
      left_q <= s_tdata_i[51:46];
    end else if (cmd_i.emit) begin
      blk_q  <= blk_q + lcds_pkg::BLK_W'(count);
      addr_q <= addr_q + (lcds_pkg::ADDR_W'(count) << BLK_SHIFT);
      left_q <= left_q - count;
    end
    if (cmd_i.cap_sec) begin
      track_q <= div_quo;
      sec_q   <= div_rem[lcds_pkg::SPT_W-1:0];
    end
    if (cmd_i.cap_cyl) begin
      head_q <= div_rem;
      cyl_q  <= div_quo[lcds_pkg::CYL_W-1:0];
    end
    if (cmd_i.emit) begin
      out_data_q <= {2'b00, addr_q, count, xfer[3:0], xfer[19:4],
                     sector_byte, head_byte, cyl_q[7:0]};
      out_last_q <= (left_q == count);
      out_user_q <= bounce;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tlast_o  = out_last_q;
  assign m_tuser_o  = out_user_q;

  assign sts_o.in_empty   = (s_tdata_i[51:46] == '0);
  assign sts_o.div_done   = div_done;
  assign sts_o.last_chunk = (left_q == count);
  assign sts_o.out_free   = !out_valid_q || m_tready_i;

`ifndef SYNTHESIS
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (count != '0))
    else $error("chunk of zero blocks emitted");
  a_sec_in_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (sec_q < spt_eff))
    else $error("sector outside track");
  a_no_window_cross: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && !bounce) |->
      (({1'b0, win_low} + (ROOM_W'(count) << BLK_SHIFT)) <= ROOM_W'(DMA_WINDOW_BYTES)))
    else $error("chunk crosses DMA window");
`endif

endmodule

// File: hdl/lcds_ctrl.sv
// Controller: sequences load, the two divisions and the emit of each command.
// Uses lcds_pkg for the command and status structs.
module lcds_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  lcds_pkg::lcds_sts_t  sts_i,
  output lcds_pkg::lcds_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEC_GO,
    S_SEC_WAIT,
    S_CYL_GO,
    S_CYL_WAIT,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          // drop empty requests
          if (!sts_i.in_empty) state_d = S_SEC_GO;
        end
      end
      S_SEC_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = lcds_pkg::DIV_SEC;
        state_d         = S_SEC_WAIT;
      end
      S_SEC_WAIT: begin
        cmd_o.div_sel = lcds_pkg::DIV_SEC;
        if (sts_i.div_done) begin
          cmd_o.cap_sec = 1'b1;
          state_d       = S_CYL_GO;
        end
      end
      S_CYL_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = lcds_pkg::DIV_CYL;
        state_d         = S_CYL_WAIT;
      end
      S_CYL_WAIT: begin
        cmd_o.div_sel = lcds_pkg::DIV_CYL;
        if (sts_i.div_done) begin
          cmd_o.cap_cyl = 1'b1;
          state_d       = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.last_chunk ? S_IDLE : S_SEC_GO;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_emit_idle_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && !sts_i.last_chunk) |=> (state_q == S_SEC_GO))
    else $error("request ended before its last chunk");
  a_load_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (state_q == S_IDLE))
    else $error("request loaded while busy");
`endif

endmodule

// File: hdl/lba_to_chs_dma_splitter_top.sv
// Channel    Dir  Handshake                 Content
// s_axis     in   s_axis_tvalid/tready      read request
// m_axis     out  m_axis_tvalid/tready      CHS read command, tlast on the final one
// cfg        in   cfg_we (no back-pressure) raw head count, sectors per track, bounce address
//
// Each command takes two passes of one shared 26-step divider (block by sectors per
// track, then track by heads) plus start, capture and emit.
// Empty requests are dropped at load and produce no command.
// Requests are taken one at a time; a new one is accepted while the last command waits.
// Output stalls hold the controller in its emit state. Reset is asynchronous, active low.
module lba_to_chs_dma_splitter_top #(
  parameter int BLOCK_BYTES      = 512,
  parameter int DMA_WINDOW_BYTES = 65536
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lcds_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lcds_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // start_block[25:0], dest_address[45:26], block_count[51:46], zero pad
  input  logic [lcds_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // cylinder_low[7:0], head_byte[15:8], sector_byte[23:16], buffer_segment[39:24],
  // buffer_offset[43:40], chunk_blocks[49:44], copy_target[69:50], zero pad
  output logic [lcds_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  output logic                                m_axis_tlast_o,
  // bounced[0]
  output logic                                m_axis_tuser_o
);

  lcds_pkg::lcds_cmd_t cmd;
  lcds_pkg::lcds_sts_t sts;

  lcds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lcds_dp #(
    .BLOCK_BYTES      (BLOCK_BYTES),
    .DMA_WINDOW_BYTES (DMA_WINDOW_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tdata_i   (s_axis_tdata_i),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tlast_o   (m_axis_tlast_o),
    .m_tuser_o   (m_axis_tuser_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// File: dv/lba_to_chs_dma_splitter_top_test.sv
// Self-checking testbench for lba_to_chs_dma_splitter_top: drives read requests, predicts
// the CHS command stream in a scoreboard class and compares every output beat.
// Depends on lcds_pkg and the RTL top level only.
module lba_to_chs_dma_splitter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLOCK_BYTES      = 512;
  localparam int DMA_WINDOW_BYTES = 65536;
  localparam int HALF_PERIOD      = 10;
  localparam int RANDOM_PHASES    = 8;
  localparam int PHASE_ITEMS      = 52;
  localparam int SETTLE_CYCLES    = 120;
  localparam int HOLD_CYCLES      = 700;
  localparam int LIMIT_CYCLES     = 20_000_000;

  typedef struct packed {
    logic [7:0]  cylinder_low;
    logic [7:0]  head_byte;
    logic [7:0]  sector_byte;
    logic [15:0] buffer_segment;
    logic [3:0]  buffer_offset;
    logic [5:0]  chunk_blocks;
    logic        bounced;
    logic [19:0] copy_target;
    logic        last;
  } chs_cmd_t;

  class chs_scoreboard;
    logic [7:0]  raw_heads;
    logic [5:0]  spt_reg;
    logic [19:0] bounce_addr;
    chs_cmd_t    pending_cmds[$];
    int          errors;
    int          requests;
    int          cmds_checked;
    int          bounced_cmds;

    function new();
      raw_heads   = lcds_pkg::RST_RAW_HEADS;
      spt_reg     = lcds_pkg::RST_SPT;
      bounce_addr = lcds_pkg::RST_BOUNCE;
    endfunction

    function void write_reg(logic [lcds_pkg::CFG_IDX_W-1:0] idx,
                            logic [lcds_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        lcds_pkg::CFG_RAW_HEADS: raw_heads = data[7:0];
        lcds_pkg::CFG_SPT:       spt_reg = data[5:0];
        lcds_pkg::CFG_BOUNCE:    bounce_addr = data;
        default: ;
      endcase
    endfunction

    // Split one request into the commands the block should emit
    function void note_request(logic [25:0] start_blk, logic [19:0] dest, logic [5:0] count);
      int unsigned heads, spt, per_cyl, blk, addr, left;
      int unsigned cyl, sec, head, room, chunk, xfer;
      chs_cmd_t cmd;
      heads = raw_heads;
      if (raw_heads >= lcds_pkg::TYPE3_MIN && raw_heads[5:0] == lcds_pkg::TYPE3_HEADS)
        heads = raw_heads[5:0];
      if (heads == 0) heads = 1;
      spt = (spt_reg == 0) ? 1 : spt_reg;
      per_cyl = heads * spt;
      blk = start_blk;
      addr = dest;
      left = count;
      requests++;
      while (left > 0) begin
        cyl  = blk / per_cyl;
        sec  = blk % spt;
        head = (blk % per_cyl) / spt;
        room = DMA_WINDOW_BYTES - (addr % DMA_WINDOW_BYTES);
        if (room < BLOCK_BYTES) begin
          chunk = 1;
          xfer = bounce_addr;
          cmd.bounced = 1'b1;
        end else begin
          chunk = left;
          room = room / BLOCK_BYTES;
          if (chunk > room) chunk = room;
          if (chunk > spt - sec) chunk = spt - sec;
          xfer = addr;
          cmd.bounced = 1'b0;
        end
        cmd.cylinder_low   = 8'(cyl);
        cmd.head_byte      = 8'(head + ((cyl >> 4) & 32'hC0));
        cmd.sector_byte    = 8'(sec + 1 + ((cyl >> 2) & 32'hC0));
        cmd.buffer_segment = 16'(xfer >> 4);
        cmd.buffer_offset  = 4'(xfer);
        cmd.chunk_blocks   = 6'(chunk);
        cmd.copy_target    = 20'(addr);
        addr = 20'(addr + chunk * BLOCK_BYTES);
        blk  = 26'(blk + chunk);
        left = left - chunk;
        cmd.last = (left == 0);
        pending_cmds.push_back(cmd);
      end
    endfunction

    function void cmp(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_command(logic [lcds_pkg::OUT_TDATA_W-1:0] data, logic last_flag,
                                logic bounce_flag);
      chs_cmd_t want;
      cmds_checked++;
      if (bounce_flag) bounced_cmds++;
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected command, expected none, actual tdata 0x%0h",
                 $time, data);
        errors++;
        return;
      end
      want = pending_cmds.pop_front();
      cmp("cylinder_low", want.cylinder_low, data[7:0]);
      cmp("head_byte", want.head_byte, data[15:8]);
      cmp("sector_byte", want.sector_byte, data[23:16]);
      cmp("buffer_segment", want.buffer_segment, data[39:24]);
      cmp("buffer_offset", want.buffer_offset, data[43:40]);
      cmp("chunk_blocks", want.chunk_blocks, data[49:44]);
      cmp("copy_target", want.copy_target, data[69:50]);
      cmp("bounced", want.bounced, bounce_flag);
      cmp("last", want.last, last_flag);
    endfunction
  endclass

  logic                                clk_i = 1'b0;
  logic                                rst_ni;
  logic                                cfg_we_i;
  logic [lcds_pkg::CFG_IDX_W-1:0]      cfg_index_i;
  logic [lcds_pkg::CFG_DATA_W-1:0]     cfg_data_i;
  logic                                s_axis_tvalid_i;
  logic                                s_axis_tready_o;
  logic [lcds_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i;
  logic                                m_axis_tvalid_o;
  logic                                m_axis_tready_i = 1'b0;
  logic [lcds_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o;
  logic                                m_axis_tlast_o;
  logic                                m_axis_tuser_o;

  chs_scoreboard sb;
  int            tx_idle_pct;
  int            rx_stall_pct;
  bit            hold_req;
  int            hold_left;
  int            cycle_count;
  int            settings_used;

  lba_to_chs_dma_splitter_top #(
    .BLOCK_BYTES     (BLOCK_BYTES),
    .DMA_WINDOW_BYTES(DMA_WINDOW_BYTES)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Receiver: a requested hold-off wins over the random stall pattern
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_command(m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles, %0d commands outstanding",
               $time, cycle_count, sb.pending_cmds.size());
      $display("lba_to_chs_dma_splitter_top test failed");
      $finish;
    end
  end

  // Enter and leave at a falling edge; tvalid stays high into the next beat
  task automatic send_request(input logic [25:0] blk, input logic [19:0] addr,
                              input logic [5:0] count);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'b0, count, addr, blk};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_request(blk, addr, count);
    @(negedge clk_i);
  endtask

  task automatic send_random();
    logic [25:0] blk;
    logic [19:0] addr;
    logic [5:0]  count;
    int          r;
    r = $urandom_range(99);
    if (r < 40)      blk = 26'($urandom);
    else if (r < 70) blk = 26'($urandom_range(0, 5000));
    else if (r < 85) blk = 26'h3FFFFFF - 26'($urandom_range(0, 200));
    else             blk = 26'($urandom_range(0, 20_000_000));
    r = $urandom_range(99);
    if (r < 30)      addr = {4'($urandom), 16'hFFFF - 16'($urandom_range(0, 2047))};
    else if (r < 45) addr = {4'($urandom), 16'(17'h10000 - $urandom_range(1, 8) * BLOCK_BYTES)};
    else if (r < 55) addr = {4'($urandom), 16'h0000};
    else             addr = 20'($urandom);
    r = $urandom_range(99);
    if (r < 8)       count = 6'd0;
    else if (r < 70) count = 6'($urandom_range(1, 8));
    else if (r < 92) count = 6'($urandom_range(9, 40));
    else             count = 6'($urandom_range(41, 63));
    send_request(blk, addr, count);
  endtask

  // Drop tvalid, wait for every predicted command, then cover any empty request in flight
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_cmds.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_config(input logic [7:0] heads, input logic [5:0] spt,
                            input logic [19:0] bounce);
    logic [lcds_pkg::CFG_DATA_W-1:0] vals[3];
    logic [lcds_pkg::CFG_IDX_W-1:0]  idxs[3];
    vals = '{20'(heads), 20'(spt), bounce};
    idxs = '{lcds_pkg::CFG_RAW_HEADS, lcds_pkg::CFG_SPT, lcds_pkg::CFG_BOUNCE};
    for (int k = 0; k < 3; k++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idxs[k];
      cfg_data_i  <= vals[k];
      @(posedge clk_i);
      sb.write_reg(idxs[k], vals[k]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  initial begin : main_seq
    logic [7:0]  heads_tbl[RANDOM_PHASES];
    logic [5:0]  spt_tbl[RANDOM_PHASES];
    logic [19:0] bounce_tbl[RANDOM_PHASES];
    sb = new();
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = lcds_pkg::CFG_RAW_HEADS;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    tx_idle_pct     = 0;
    rx_stall_pct    = 0;
    hold_req        = 1'b0;
    hold_left       = 0;
    cycle_count     = 0;
    settings_used   = 0;
    heads_tbl  = '{8'd16, 8'd255, 8'd0, 8'd1, 8'h50, 8'hD0, 8'($urandom), 8'h40};
    spt_tbl    = '{6'd63, 6'd63, 6'd0, 6'd1, 6'd17, 6'd63, 6'($urandom), 6'd32};
    bounce_tbl = '{20'h12340, 20'hFFFFF, 20'h00000, 20'hFFE00,
                   20'($urandom), 20'($urandom), 20'($urandom), 20'h0FE00};

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed requests under the reset geometry: 16 heads, 63 sectors
    send_request(26'd0, 20'h00000, 6'd1);
    send_request(26'd0, 20'h00000, 6'd63);
    send_request(26'd0, 20'h00000, 6'd0);
    send_request(26'h3FFFFFF, 20'hFFFFF, 6'd63);
    send_request(26'd62, 20'h0FE00, 6'd4);
    send_request(26'd100, 20'h1FF80, 6'd3);
    send_request(26'd5000000, 20'h12345, 6'd20);
    send_request(26'h3FFFFF0, 20'hFFE00, 6'd40);
    send_request(26'd4128767, 20'h40000, 6'd2);
    send_request(26'd4128768, 20'hF0000, 6'd1);
    wait_idle();

    // Many heads: head plus the top cylinder bits overflows the head byte
    set_config(8'd255, 6'd63, 20'hFFFFF);
    send_request(26'd49367430, 20'hAFFF0, 6'd5);
    send_request(26'd49367492, 20'h3FE00, 6'd63);
    send_request(26'h3FFFFFF, 20'h00000, 6'd63);
    wait_idle();

    // Zero heads and zero sectors fall back to one of each
    set_config(8'd0, 6'd0, 20'h0FE00);
    send_request(26'd7, 20'h0FF00, 6'd3);
    send_request(26'h3FFFFFF, 20'h7FE00, 6'd2);
    wait_idle();

    // Type-3 encoding masks to 16 heads; 0x40 does not match and stays 64
    set_config(8'hD0, 6'd63, 20'h20000);
    send_request(26'd3044, 20'h05000, 6'd10);
    wait_idle();
    set_config(8'h40, 6'd63, 20'h20000);
    send_request(26'd3044, 20'h0FC00, 6'd10);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_config(heads_tbl[p], spt_tbl[p], bounce_tbl[p]);
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 66; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 66; end
        default: begin tx_idle_pct = 9; rx_stall_pct = 9; end
      endcase
      if (p == 2) begin
        // Long receiver hold-off while requests keep coming: fill the block
        @(posedge clk_i);
        hold_req = 1'b1;
        @(negedge clk_i);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 5 && i == PHASE_ITEMS / 2) wait_idle();
        send_random();
      end
      wait_idle();
    end

    $display("Ran %0d requests into %0d commands, %0d of them bounced, over %0d settings",
             sb.requests, sb.cmds_checked, sb.bounced_cmds, settings_used);
    $display("Geometries included zero, single and maximal heads and sectors, type-3 heads");
    if (sb.errors == 0 && sb.pending_cmds.size() == 0) begin
      $display("lba_to_chs_dma_splitter_top test passed");
    end else begin
      $display("%0t: %0d mismatches, %0d commands never arrived",
               $time, sb.errors, sb.pending_cmds.size());
      $display("lba_to_chs_dma_splitter_top test failed");
    end
    $finish;
  end

endmodule
